/* rtl/core/assert_macros.svh */
// assertion macros for the rtl, used by the stack unit top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define TMS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tms assertion failed");

// condition must never be true outside reset
`define TMS_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("tms forbidden condition seen");

`endif

/* rtl/core/tms_pkg.sv */
// package for the transform matrix stack: payload types, codes and fixed-point helpers
package tms_pkg;

  localparam int unsigned STACK_LEVELS_DEF = 16;

  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_POP  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OVER    = 2'd1;
  localparam logic [1:0] ST_UNDER   = 2'd2;
  localparam logic [1:0] ST_PENDING = 2'd3;

  localparam logic [31:0] Q_ONE = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]         func;
    logic [1:0]         row_index;
    logic [1:0]         col_index;
    logic signed [31:0] elem_0;
    logic signed [31:0] elem_1;
    logic signed [31:0] elem_2;
    logic signed [31:0] elem_3;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [4:0]         depth_now;
  } rsp_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v[49:31] == {19{v[49]}}) begin
      r = v[31:0];
    end else if (v[49]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

/* rtl/core/tms_ram.sv */
// generic single-clock ram, one write port and one registered read port
module tms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/tms_mac.sv */
// four-lane multiply-accumulate for one result row, with saturation
module tms_mac (
  input  logic               clk,
  input  logic               rst,
  input  tms_pkg::mac_ctl_t  ctl,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b [4],
  output logic               row_done,
  output logic signed [31:0] res [4]
);
  import tms_pkg::*;

  mac_ctl_t           ctl_a;
  logic signed [63:0] prod [4];
  logic signed [49:0] acc  [4];
  logic signed [49:0] sum  [4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sum[j] = (ctl_a.first ? 50'sd0 : acc[j]) + 50'(signed'(prod[j][63:16]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a    <= '0;
      row_done <= 1'b0;
    end else begin
      ctl_a    <= ctl;
      row_done <= ctl_a.valid && ctl_a.last;
    end
    for (int j = 0; j < 4; j++) begin
      prod[j] <= a * b[j];
      if (ctl_a.valid) begin
        acc[j] <= sum[j];
        if (ctl_a.last) begin
          res[j] <= sat32(sum[j]);
        end
      end
    end
  end

endmodule

/* rtl/core/transform_matrix_stack_unit.sv */
// top level of the 4x4 transform matrix stack
//
// req channel (valid/ready) carries one item: push row, pop or read element.
// rsp channel (valid/ready) returns exactly one result per item, in order.
// push rows 0..2 are written to the incoming row buffer and answer with
// status pending; a push of row 3 onto a non-full stack runs the product of
// the current top and the buffered matrix (a copy on an empty stack).
// that product steps through the top elements on four multiply-accumulate
// lanes, with one stack ram read and one stack ram write per cycle, through
// the ram read, product and accumulate registers and a row drain that writes
// each finished row of four results back into the stack ram.
// pop, full/empty cases and other codes pass from the transfer through the
// done state to the output register; a read first passes the read state,
// which takes the registered output of the stack ram.
// one item is in work at a time; the next item is taken while an earlier
// result still waits in the output register, and a finished item holds
// until that register frees up when the receiver stalls.
// reset empties the stack (level count zero); ram contents are not cleared.
`include "assert_macros.svh"

module transform_matrix_stack_unit #(
  parameter int unsigned STACK_LEVELS = tms_pkg::STACK_LEVELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  tms_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output tms_pkg::rsp_t rsp
);
  import tms_pkg::*;

  localparam int unsigned LW    = $clog2(STACK_LEVELS + 1);
  localparam int unsigned DEPTH = STACK_LEVELS * 16;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t             state;
  logic [LW-1:0]      level;
  logic [LW-1:0]      level_m1;
  logic [3:0]         cnt;
  logic               iss;
  logic [3:0]         wcnt;
  logic               wact;
  logic               wr_go;
  logic [1:0]         pend_status;
  logic signed [31:0] pend_value;
  mac_ctl_t           d1;
  logic               d1_diag;

  logic [LW+3:0]      rd_full;
  logic [LW+3:0]      wr_full;
  logic [AW-1:0]      stack_raddr;
  logic [AW-1:0]      stack_waddr;
  logic               stack_we;
  logic [31:0]        stack_rdata;
  logic signed [31:0] stack_wdata;
  logic               inc_we;
  logic [127:0]       inc_rdata;

  logic signed [31:0] mac_a;
  logic signed [31:0] mac_b [4];
  logic               row_done;
  logic signed [31:0] row_res [4];
  logic               accept;
  logic               full;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign level_m1  = level - LW'(1);
  assign full      = (level >= LW'(STACK_LEVELS));

  always_comb begin
    if (state == S_IDLE) begin
      rd_full = {level_m1, req.row_index, req.col_index};
    end else begin
      rd_full = {level_m1, cnt};
    end
  end
  assign stack_raddr = rd_full[AW-1:0];
  assign wr_full     = {level, wcnt};
  assign stack_waddr = wr_full[AW-1:0];
  // a finished row is written out starting in the cycle it appears
  assign wr_go       = row_done || wact;
  assign stack_we    = (state == S_MUL) && wr_go;
  assign stack_wdata = row_res[wcnt[1:0]];
  assign inc_we      = accept && (req.func == FUNC_PUSH);

  tms_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  tms_ram #(.WIDTH(128), .DEPTH(4)) u_row_ram (
    .clk   (clk),
    .we    (inc_we),
    .waddr (req.row_index),
    .wdata ({req.elem_3, req.elem_2, req.elem_1, req.elem_0}),
    .raddr (cnt[1:0]),
    .rdata (inc_rdata)
  );

  // empty stack: the top is replaced by identity so the product is a copy
  always_comb begin
    if (level == '0) begin
      mac_a = d1_diag ? signed'(Q_ONE) : 32'sd0;
    end else begin
      mac_a = signed'(stack_rdata);
    end
    for (int j = 0; j < 4; j++) begin
      mac_b[j] = signed'(inc_rdata[32*j +: 32]);
    end
  end

  tms_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (d1),
    .a        (mac_a),
    .b        (mac_b),
    .row_done (row_done),
    .res      (row_res)
  );

  always_ff @(posedge clk) begin
    d1_diag <= (cnt[3:2] == cnt[1:0]);
    if (rst) begin
      state     <= S_IDLE;
      level     <= '0;
      iss       <= 1'b0;
      wact      <= 1'b0;
      cnt       <= '0;
      wcnt      <= '0;
      d1        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      d1.valid <= (state == S_MUL) && iss;
      d1.first <= (cnt[1:0] == 2'd0);
      d1.last  <= (cnt[1:0] == 2'd3);
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pend_value <= 32'sd0;
            case (req.func)
              FUNC_PUSH: begin
                if (req.row_index != 2'd3) begin
                  pend_status <= ST_PENDING;
                  state       <= S_DONE;
                end else if (full) begin
                  pend_status <= ST_OVER;
                  state       <= S_DONE;
                end else begin
                  cnt   <= '0;
                  wcnt  <= '0;
                  iss   <= 1'b1;
                  wact  <= 1'b0;
                  state <= S_MUL;
                end
              end
              FUNC_POP: begin
                if (level == '0) begin
                  pend_status <= ST_UNDER;
                end else begin
                  pend_status <= ST_OK;
                  level       <= level_m1;
                end
                state <= S_DONE;
              end
              FUNC_READ: begin
                if (level == '0) begin
                  pend_status <= ST_UNDER;
                  state       <= S_DONE;
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
                pend_status <= ST_OK;
                state       <= S_DONE;
              end
            endcase
          end
        end
        S_MUL: begin
          if (iss) begin
            cnt <= cnt + 4'd1;
            if (cnt == 4'd15) begin
              iss <= 1'b0;
            end
          end
          if (row_done) begin
            wact <= 1'b1;
          end else if (wact && wcnt[1:0] == 2'd3) begin
            wact <= 1'b0;
          end
          if (wr_go) begin
            wcnt <= wcnt + 4'd1;
            if (wcnt == 4'd15) begin
              level       <= level + LW'(1);
              pend_status <= ST_OK;
              state       <= S_DONE;
            end
          end
        end
        S_READ: begin
          pend_value  <= signed'(stack_rdata);
          pend_status <= ST_OK;
          state       <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid      <= 1'b1;
            rsp.status     <= pend_status;
            rsp.read_value <= pend_value;
            rsp.depth_now  <= 5'(level);
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TMS_ASSERT(a_level_bound, clk, rst, level <= LW'(STACK_LEVELS))
  `TMS_ASSERT(a_write_in_mul, clk, rst, stack_we |-> state == S_MUL)
  `TMS_ASSERT(a_mul_has_room, clk, rst, state == S_MUL |-> level < LW'(STACK_LEVELS))
  `TMS_NEVER(a_row_outside_mul, clk, rst, row_done && state != S_MUL)

endmodule

/* verif/tms_checker.sv */
`timescale 1ns / 100ps
// result checker for the transform matrix stack: predicts each result and compares it
module tms_checker #(
  parameter int unsigned LEVELS = tms_pkg::STACK_LEVELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  tms_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  tms_pkg::rsp_t rsp,
  output int            fail_count,
  output int            waiting,
  output int            checked,
  output int            overflows,
  output int            underflows
);
  import tms_pkg::*;

  localparam logic [1:0] LAST_ROW = 2'd3;
  localparam longint SAT_HI = 64'sh0000_0000_7fff_ffff;
  localparam longint SAT_LO = 64'shffff_ffff_8000_0000;

  logic [31:0] mat_mem [LEVELS*16];
  logic [31:0] row_buf [16];
  int unsigned depth;
  rsp_t result_q [$];

  // q16.16 product, low 16 bits dropped toward minus infinity
  function automatic longint fix_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 16;
  endfunction

  // one element of top times buffered matrix, saturated to 32 bits
  function automatic logic [31:0] dot_sat(int unsigned base, int i, int j);
    longint acc;
    acc = 0;
    for (int k = 0; k < 4; k++) begin
      acc += fix_mul(mat_mem[base + i*4 + k], row_buf[k*4 + j]);
    end
    if (acc > SAT_HI) begin
      acc = SAT_HI;
    end else if (acc < SAT_LO) begin
      acc = SAT_LO;
    end
    return acc[31:0];
  endfunction

  function automatic rsp_t next_result(req_t it);
    rsp_t r;
    logic [3:0][31:0] words;
    int unsigned dst;
    r = '0;
    words = {it.elem_3, it.elem_2, it.elem_1, it.elem_0};
    case (it.func)
      FUNC_PUSH: begin
        for (int j = 0; j < 4; j++) begin
          row_buf[it.row_index*4 + j] = words[j];
        end
        if (it.row_index != LAST_ROW) begin
          r.status = ST_PENDING;
        end else if (depth >= LEVELS) begin
          r.status = ST_OVER;
        end else begin
          dst = depth * 16;
          for (int e = 0; e < 16; e++) begin
            mat_mem[dst + e] = (depth == 0) ? row_buf[e] : dot_sat((depth - 1) * 16, e / 4, e % 4);
          end
          depth++;
          r.status = ST_OK;
        end
      end
      FUNC_POP: begin
        if (depth == 0) begin
          r.status = ST_UNDER;
        end else begin
          depth--;
          r.status = ST_OK;
        end
      end
      FUNC_READ: begin
        if (depth == 0) begin
          r.status = ST_UNDER;
        end else begin
          r.read_value = mat_mem[(depth - 1) * 16 + it.row_index*4 + it.col_index];
          r.status = ST_OK;
        end
      end
      default: begin
        r.status = ST_OK;
      end
    endcase
    r.depth_now = 5'(depth);
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      depth = 0;
      result_q.delete();
    end else begin
      if (req_valid && req_ready) begin
        want = next_result(req);
        if (want.status == ST_OVER) overflows++;
        if (want.status == ST_UNDER) underflows++;
        result_q.push_back(want);
      end
      if (rsp_valid && rsp_ready) begin
        if (result_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          fail_count++;
        end else begin
          want = result_q.pop_front();
          checked++;
          if (rsp.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.read_value !== want.read_value) begin
            $error("read_value expected %0d got %0d", want.read_value, rsp.read_value);
            fail_count++;
          end
          if (rsp.depth_now !== want.depth_now) begin
            $error("depth_now expected %0d got %0d", want.depth_now, rsp.depth_now);
            fail_count++;
          end
        end
      end
    end
    waiting <= result_q.size();
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// testbench top for the transform matrix stack: stimulus, idling and verdict
module tb;
  import tms_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam logic [1:0] LAST_ROW = 2'd3;
  localparam int RANDOM_ITEMS = 1800;
  localparam int QUIET_TAIL = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int fail_count;
  int waiting;
  int checked;
  int overflows;
  int underflows;
  int sent = 0;
  bit quiet = 1'b0;
  bit tx_bursty = 1'b1;
  bit rx_bursty = 1'b1;
  int stall_left = 0;

  transform_matrix_stack_unit dut (
    .clk,
    .rst,
    .req_valid,
    .req_ready,
    .req,
    .rsp_valid,
    .rsp_ready,
    .rsp
  );

  tms_checker #(.LEVELS(STACK_LEVELS_DEF)) chk (
    .clk,
    .rst,
    .req_valid,
    .req_ready,
    .req,
    .rsp_valid,
    .rsp_ready,
    .rsp,
    .fail_count,
    .waiting,
    .checked,
    .overflows,
    .underflows
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      stall_left = 0;
      rsp_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      rsp_ready <= 1'b0;
    end else if (rx_bursty && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 15);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  function automatic logic [31:0] pick_word();
    int unsigned sel;
    logic [31:0] w;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      w = $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
    end else if (sel < 50) begin
      w = Q_ONE + $urandom_range(0, 32'h200) - 32'h100;
    end else if (sel < 62) begin
      case ($urandom_range(0, 5))
        0: w = 32'h8000_0000;
        1: w = 32'h7fff_ffff;
        2: w = '0;
        3: w = '1;
        4: w = Q_ONE;
        default: w = -Q_ONE;
      endcase
    end else begin
      w = $urandom();
    end
    return w;
  endfunction

  // style 0 gives near-identity rows so deep products stay in range
  function automatic logic [31:0] elem_for(int style, int r, int c);
    logic [31:0] w;
    if (style == 0) begin
      w = $urandom_range(0, 32'h1000) - 32'h800;
      if (r == c) w = w + Q_ONE;
    end else begin
      w = pick_word();
    end
    return w;
  endfunction

  function automatic req_t func_item(logic [1:0] f, logic [1:0] row, logic [1:0] col);
    req_t it;
    it.func = f;
    it.row_index = row;
    it.col_index = col;
    it.elem_0 = $urandom();
    it.elem_1 = $urandom();
    it.elem_2 = $urandom();
    it.elem_3 = $urandom();
    return it;
  endfunction

  function automatic req_t push_item(logic [1:0] row, int style);
    req_t it;
    it = func_item(FUNC_PUSH, row, 2'($urandom()));
    it.elem_0 = elem_for(style, int'(row), 0);
    it.elem_1 = elem_for(style, int'(row), 1);
    it.elem_2 = elem_for(style, int'(row), 2);
    it.elem_3 = elem_for(style, int'(row), 3);
    return it;
  endfunction

  function automatic req_t row_item(logic [1:0] row, logic [31:0] w0, logic [31:0] w1,
                                    logic [31:0] w2, logic [31:0] w3);
    req_t it;
    it = func_item(FUNC_PUSH, row, 2'($urandom()));
    it.elem_0 = w0;
    it.elem_1 = w1;
    it.elem_2 = w2;
    it.elem_3 = w3;
    return it;
  endfunction

  task automatic send(input req_t it);
    int gap;
    if (!quiet && tx_bursty && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (it.func != FUNC_NONE) sent++;
  endtask

  // rows 0..2 in order or shuffled, maybe one rewritten, then row 3
  task automatic push_matrix();
    int style;
    int j;
    logic [1:0] order [3];
    logic [1:0] t;
    style = $urandom_range(0, 1);
    order[0] = 2'd0;
    order[1] = 2'd1;
    order[2] = 2'd2;
    if ($urandom_range(0, 3) == 0) begin
      for (int k = 2; k > 0; k--) begin
        j = $urandom_range(0, k);
        t = order[k];
        order[k] = order[j];
        order[j] = t;
      end
    end
    for (int k = 0; k < 3; k++) begin
      send(push_item(order[k], style));
    end
    if ($urandom_range(0, 7) == 0) send(push_item(2'($urandom_range(0, 2)), style));
    send(push_item(LAST_ROW, style));
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  initial begin
    int base;
    int left;
    int pick;
    bit fill;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty stack cases and the unused selector
    send(func_item(FUNC_READ, 2'd0, 2'd0));
    send(func_item(FUNC_POP, 2'($urandom()), 2'($urandom())));
    send(row_item(2'd0, 32'h8000_0000, 32'h7fff_ffff, '0, '1));
    send(func_item(FUNC_NONE, 2'($urandom()), 2'($urandom())));

    // first matrix with extreme values, copied onto the empty stack
    send(row_item(2'd0, 32'h7fff_ffff, 32'h8000_0000, '0, '1));
    send(row_item(2'd1, Q_ONE, -Q_ONE, 32'h8000_0000, 32'h7fff_ffff));
    send(row_item(2'd2, '0, '0, Q_ONE, '0));
    send(row_item(LAST_ROW, '1, 32'h7fff_ffff, '0, Q_ONE));
    send(func_item(FUNC_READ, 2'd3, 2'd3));
    send(func_item(FUNC_READ, 2'd0, 2'd1));

    // products that saturate both ways, then fill to the top and overflow
    send(row_item(LAST_ROW, 32'h8000_0000, 32'h7fff_ffff, -Q_ONE, '1));
    for (int k = 0; k < 14; k++) begin
      send(push_item(LAST_ROW, 1));
    end
    send(push_item(LAST_ROW, 0));
    send(push_item(2'd1, 0));
    send(func_item(FUNC_READ, 2'd2, 2'd2));
    send(func_item(FUNC_POP, 2'($urandom()), 2'($urandom())));

    // all buffer rows are written by now, so any row 3 push is legal
    base = sent;
    fill = 1'b0;
    left = 0;
    while (sent < base + RANDOM_ITEMS) begin
      if (left <= 0) begin
        wait_drained();
        fill = !fill;
        left = $urandom_range(40, 120);
        tx_bursty = ($urandom_range(0, 2) != 0);
        rx_bursty = ($urandom_range(0, 2) != 0);
      end
      pick = $urandom_range(0, 99);
      if (fill) begin
        if (pick < 45) push_matrix();
        else if (pick < 62) send(push_item(LAST_ROW, $urandom_range(0, 1)));
        else if (pick < 82) send(func_item(FUNC_READ, 2'($urandom()), 2'($urandom())));
        else if (pick < 90) send(func_item(FUNC_POP, 2'($urandom()), 2'($urandom())));
        else if (pick < 96) send(push_item(2'($urandom_range(0, 2)), $urandom_range(0, 1)));
        else send(func_item(FUNC_NONE, 2'($urandom()), 2'($urandom())));
      end else begin
        if (pick < 8) push_matrix();
        else if (pick < 14) send(push_item(LAST_ROW, $urandom_range(0, 1)));
        else if (pick < 60) send(func_item(FUNC_POP, 2'($urandom()), 2'($urandom())));
        else if (pick < 88) send(func_item(FUNC_READ, 2'($urandom()), 2'($urandom())));
        else if (pick < 94) send(push_item(2'($urandom_range(0, 2)), $urandom_range(0, 1)));
        else send(func_item(FUNC_NONE, 2'($urandom()), 2'($urandom())));
      end
      left--;
      quiet = (sent >= base + RANDOM_ITEMS - QUIET_TAIL);
    end

    wait_drained();
    repeat (40) @(posedge clk);
    $display("covered %0d pushes, pops and reads with %0d results compared", sent, checked);
    $display("stack overflow cases %0d, underflow or empty cases %0d", overflows, underflows);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8_400_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
